FILE: rtl/prc_pkg.sv
// prc_pkg: shared types and constants of the progress record checker
// no dependencies; imported by prc_crc, prc_parser and progress_record_checker

package prc_pkg;

  // record layout constants
  localparam logic [31:0] RECORD_MAGIC     = 32'h4550_4150;
  localparam logic [7:0]  RECORD_SCHEMA    = 8'd1;
  localparam int unsigned MIN_RECORD_BYTES = 4 + 1 + 8 + 4;
  localparam logic [31:0] CRC_POLY         = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT         = 32'hffff_ffff;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LOWEST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_HIGHEST = 8'd1;

  // parse stages
  typedef enum logic [3:0] {
    ST_MAGIC  = 4'd0,
    ST_SCHEMA = 4'd1,
    ST_SEQ    = 4'd2,
    ST_LEN1   = 4'd3,
    ST_STR1   = 4'd4,
    ST_LEN2   = 4'd5,
    ST_STR2   = 4'd6,
    ST_COUNT  = 4'd7,
    ST_INDEX  = 4'd8,
    ST_PHASE  = 4'd9,
    ST_DONE   = 4'd10
  } prc_stage_e;

  // parser status after the current byte, before end-of-record clearing
  typedef struct packed {
    logic        fault;
    logic        done;
    logic [63:0] seq_num;
    logic [31:0] count;
    logic [31:0] index;
    logic [7:0]  phase;
  } prc_parse_t;

endpackage

FILE: rtl/prc_crc.sv
// prc_crc: reflected crc-32, one byte per step_i cycle
// depends on prc_pkg

module prc_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        clear_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);
  import prc_pkg::*;

  logic [31:0] crc_q, crc_d, crc_upd;

  // eight bit-serial steps of the reflected polynomial
  always_comb begin
    logic [31:0] c;
    c = crc_q ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_upd = c;
  end

  assign crc_d = step_i ? crc_upd : crc_q;
  assign crc_o = crc_d;

  // accumulator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else if (clear_i) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

FILE: rtl/prc_parser.sv
// prc_parser: record payload field parser, one byte per step_i cycle
// depends on prc_pkg

module prc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 clear_i,
  input  logic [7:0]           data_i,
  input  logic [7:0]           phase_lo_i,
  input  logic [7:0]           phase_hi_i,
  output prc_pkg::prc_parse_t  status_o
);
  import prc_pkg::*;

  prc_stage_e  stage_q, stage_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] remain_q, remain_d;
  logic [63:0] seq_q, seq_d;
  logic [31:0] count_q, count_d;
  logic [31:0] index_q, index_d;
  logic [7:0]  phase_q, phase_d;
  logic        fault_q, fault_d;

  logic [63:0] gathered;
  logic [31:0] remain_dec;
  logic        full4, full8;

  // byte merged into the field under assembly
  assign gathered   = shift_q | ({56'd0, data_i} << {idx_q, 3'b000});
  assign full4      = (idx_q >= 3'd3);
  assign full8      = (idx_q == 3'd7);
  assign remain_dec = remain_q - 32'd1;

  // next state of the parser
  always_comb begin
    stage_d  = stage_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    remain_d = remain_q;
    seq_d    = seq_q;
    count_d  = count_q;
    index_d  = index_q;
    phase_d  = phase_q;
    fault_d  = fault_q;
    if (step_i) begin
      case (stage_q)
        ST_MAGIC: begin
          if (full4) begin
            idx_d   = 3'd0;
            shift_d = 64'd0;
            stage_d = ST_SCHEMA;
            if (gathered[31:0] != RECORD_MAGIC) fault_d = 1'b1;
          end else begin
            idx_d   = idx_q + 3'd1;
            shift_d = gathered;
          end
        end
        ST_SCHEMA: begin
          if (data_i != RECORD_SCHEMA) fault_d = 1'b1;
          stage_d = ST_SEQ;
        end
        ST_SEQ: begin
          if (full8) begin
            idx_d   = 3'd0;
            shift_d = 64'd0;
            seq_d   = gathered;
            stage_d = ST_LEN1;
            if (gathered == 64'd0) fault_d = 1'b1;
          end else begin
            idx_d   = idx_q + 3'd1;
            shift_d = gathered;
          end
        end
        ST_LEN1, ST_LEN2: begin
          if (full4) begin
            idx_d   = 3'd0;
            shift_d = 64'd0;
            if (gathered[31:0] == 32'd0) begin
              // empty string: fault, go on with the next field
              fault_d = 1'b1;
              stage_d = (stage_q == ST_LEN1) ? ST_LEN2 : ST_COUNT;
            end else begin
              remain_d = gathered[31:0];
              stage_d  = (stage_q == ST_LEN1) ? ST_STR1 : ST_STR2;
            end
          end else begin
            idx_d   = idx_q + 3'd1;
            shift_d = gathered;
          end
        end
        ST_STR1, ST_STR2: begin
          remain_d = remain_dec;
          if (remain_dec == 32'd0) begin
            stage_d = (stage_q == ST_STR1) ? ST_LEN2 : ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (full4) begin
            idx_d   = 3'd0;
            shift_d = 64'd0;
            count_d = gathered[31:0];
            stage_d = ST_INDEX;
            if (gathered[31:0] == 32'd0) fault_d = 1'b1;
          end else begin
            idx_d   = idx_q + 3'd1;
            shift_d = gathered;
          end
        end
        ST_INDEX: begin
          if (full4) begin
            idx_d   = 3'd0;
            shift_d = 64'd0;
            index_d = gathered[31:0];
            stage_d = ST_PHASE;
            if (gathered[31:0] > count_q) fault_d = 1'b1;
          end else begin
            idx_d   = idx_q + 3'd1;
            shift_d = gathered;
          end
        end
        ST_PHASE: begin
          phase_d = data_i;
          stage_d = ST_DONE;
          if (data_i < phase_lo_i || data_i > phase_hi_i) fault_d = 1'b1;
        end
        default: begin
          // trailing payload bytes
          fault_d = 1'b1;
        end
      endcase
    end
  end

  // status as seen after this byte
  assign status_o = '{
    fault:   fault_d,
    done:    (stage_d == ST_DONE),
    seq_num: seq_d,
    count:   count_d,
    index:   index_d,
    phase:   phase_d
  };

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_MAGIC;
      idx_q    <= 3'd0;
      shift_q  <= 64'd0;
      remain_q <= 32'd0;
      seq_q    <= 64'd0;
      count_q  <= 32'd0;
      index_q  <= 32'd0;
      phase_q  <= 8'd0;
      fault_q  <= 1'b0;
    end else if (clear_i) begin
      stage_q  <= ST_MAGIC;
      idx_q    <= 3'd0;
      shift_q  <= 64'd0;
      remain_q <= 32'd0;
      seq_q    <= 64'd0;
      count_q  <= 32'd0;
      index_q  <= 32'd0;
      phase_q  <= 8'd0;
      fault_q  <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
      remain_q <= remain_d;
      seq_q    <= seq_d;
      count_q  <= count_d;
      index_q  <= index_d;
      phase_q  <= phase_d;
      fault_q  <= fault_d;
    end
  end

endmodule

FILE: rtl/progress_record_checker.sv
// progress_record_checker: one byte per cycle unless stalled, registered result
// throughput: one record byte accepted every cycle while the result register is free
// latency: result valid the cycle after the transaction that carries the final byte
// the result register holds under stall; input stalls only while a result waits stalled
// reset: asynchronous, active low; clears all record state, phase window to 0..255
// depends on prc_pkg, prc_crc, prc_parser

module progress_record_checker #(
  parameter int unsigned MAX_RECORD_BYTES = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // record byte channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     record_byte_i,
  input  logic                           final_byte_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           record_ok_o,
  output logic [63:0]                    sequence_number_o,
  output logic [31:0]                    target_total_o,
  output logic [31:0]                    next_target_o,
  output logic [7:0]                     phase_code_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import prc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECORD_BYTES + 2);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RECORD_BYTES);
  localparam logic [CntW-1:0] MinCnt = CntW'(MIN_RECORD_BYTES);

  logic            accept, last, step;
  logic [3:0][7:0] tail_q, tail_d;
  logic [2:0]      fill_q, fill_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      phase_lo_q, phase_hi_q;
  logic [31:0]     crc_now;
  prc_parse_t      pstat;
  logic            ok;

  logic            out_valid_q;
  logic            ok_q;
  logic [63:0]     seq_q;
  logic [31:0]     total_q, next_q;
  logic [7:0]      phase_q;

  // handshakes
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign last        = accept && final_byte_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_lo_q <= 8'd0;
      phase_hi_q <= 8'hff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_PHASE_LOWEST)  phase_lo_q <= cfg_data_i;
      if (cfg_index_i == CFG_PHASE_HIGHEST) phase_hi_q <= cfg_data_i;
    end
  end

  // four byte delay line holding back the stored crc
  assign step = accept && (fill_q == 3'd4);
  always_comb begin
    tail_d = tail_q;
    fill_d = fill_q;
    if (accept) begin
      if (fill_q == 3'd4) begin
        tail_d = {record_byte_i, tail_q[3], tail_q[2], tail_q[1]};
      end else begin
        tail_d[fill_q[1:0]] = record_byte_i;
        fill_d = fill_q + 3'd1;
      end
    end
  end

  // saturating byte counter
  assign cnt_d = (accept && cnt_q <= MaxCnt) ? cnt_q + CntW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      fill_q <= 3'd0;
      cnt_q  <= '0;
    end else if (last) begin
      tail_q <= '0;
      fill_q <= 3'd0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload crc and field parser fed by the byte leaving the delay line
  prc_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (last),
    .data_i  (tail_q[0]),
    .crc_o   (crc_now)
  );

  prc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .clear_i    (last),
    .data_i     (tail_q[0]),
    .phase_lo_i (phase_lo_q),
    .phase_hi_i (phase_hi_q),
    .status_o   (pstat)
  );

  // end-of-record verdict
  assign ok = (cnt_d >= MinCnt) && (cnt_d <= MaxCnt) && (fill_d == 3'd4) &&
              (tail_d == ~crc_now) && !pstat.fault && pstat.done;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= last || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (last) begin
      ok_q    <= ok;
      seq_q   <= ok ? pstat.seq_num : 64'd0;
      total_q <= ok ? pstat.count : 32'd0;
      next_q  <= ok ? pstat.index : 32'd0;
      phase_q <= ok ? pstat.phase : 8'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_ok_o       = ok_q;
  assign sequence_number_o = seq_q;
  assign target_total_o    = total_q;
  assign next_target_o     = next_q;
  assign phase_code_o      = phase_q;

endmodule

FILE: rtl/prc_checker.sv
// prc_checker: port-level assertions for the progress record checker
// needs only the top-level ports; bound to progress_record_checker below

module prc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           final_byte_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           record_ok_o,
  input logic [63:0]                    sequence_number_o,
  input logic [31:0]                    target_total_o,
  input logic [31:0]                    next_target_o,
  input logic [7:0]                     phase_code_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // a new result only follows a final byte transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc && final_byte_i))
    else $error("result without final byte");

  // a non-final byte never creates a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !final_byte_i && !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result after non-final byte");

  // rejected records report zero fields
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_ok_o |-> sequence_number_o == 64'd0 &&
      target_total_o == 32'd0 && next_target_o == 32'd0 && phase_code_o == 8'd0)
    else $error("rejected record carries fields");

  // accepted records obey the field rules
  a_good_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_ok_o |-> sequence_number_o != 64'd0 &&
      target_total_o != 32'd0 && next_target_o <= target_total_o)
    else $error("accepted record breaks field rules");

endmodule

bind progress_record_checker prc_checker u_prc_checker (.*);
